/* hw/rtl/gncd_pkg.sv */
// ----------------------------------------------------------------------------
// gncd_pkg
// Shared constants, codes and types of the grid neighbour class detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gncd_pkg;

   localparam int DEF_MAX_COLUMNS = 1024;
   localparam int DEF_MAX_ROWS    = 1024;

   localparam int CELL_W     = 2;
   localparam int LINE_W     = 2 * CELL_W;   // {older, newer} per column
   localparam int DIM_W      = 11;
   localparam int POS_OUT_W  = 10;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = DIM_W;
   localparam int SLOTS      = 4;

   // cell classes
   localparam logic [CELL_W-1:0] CLS_CANDIDATE = 2'd1;
   localparam logic [CELL_W-1:0] CLS_MARKED    = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ROW_COUNT    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COLUMN_COUNT = 1'd1;

   // result slots of one window, in delivery order
   localparam int SLOT_UP_LEFT   = 0;
   localparam int SLOT_UP_RIGHT  = 1;
   localparam int SLOT_CUR_LEFT  = 2;
   localparam int SLOT_CUR_RIGHT = 3;

   typedef struct packed {
      logic [SLOTS-1:0]     mask;
      logic [POS_OUT_W-1:0] up_row;
      logic [POS_OUT_W-1:0] cur_row;
      logic [POS_OUT_W-1:0] left_col;
      logic [POS_OUT_W-1:0] right_col;
   } gncd_group_type;

endpackage

`default_nettype wire

/* hw/rtl/gncd_if.sv */
// ----------------------------------------------------------------------------
// gncd channel interfaces
// Valid/ready channels for cell beats in and hit beats out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gncd_req_if import gncd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CELL_W-1:0] cell_class;

   modport source (output valid, output cell_class, input ready);
   modport sink   (input valid, input cell_class, output ready);
endinterface

interface gncd_rsp_if import gncd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [POS_OUT_W-1:0] hit_row;
   logic [POS_OUT_W-1:0] hit_column;
   logic                 last_of_run;

   modport source (output valid, output hit_row, output hit_column, output last_of_run,
                   input ready);
   modport sink   (input valid, input hit_row, input hit_column, input last_of_run,
                   output ready);
endinterface

`default_nettype wire

/* hw/rtl/gncd_ram.sv */
// ----------------------------------------------------------------------------
// gncd_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gncd_ram import gncd_pkg::*; #(
   parameter int WIDTH = LINE_W,
   parameter int DEPTH = DEF_MAX_COLUMNS
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/gncd_window.sv */
// ----------------------------------------------------------------------------
// gncd_window
// 3x3 cell window and the judgment of the up to four centers it completes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gncd_window import gncd_pkg::*; #(
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = DEF_MAX_ROWS,
   localparam int COL_W = $clog2(MAX_COLUMNS),
   localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              shift_en,
   input  wire logic [CELL_W-1:0] older_cell,
   input  wire logic [CELL_W-1:0] newer_cell,
   input  wire logic [CELL_W-1:0] new_cell,
   input  wire logic [ROW_W-1:0]  ri,
   input  wire logic [COL_W-1:0]  ci,
   input  wire logic [DIM_W-1:0]  nr,
   input  wire logic [DIM_W-1:0]  nc,
   output gncd_group_type         group
);

   logic [CELL_W-1:0] win_ff [3][3];
   logic [CELL_W-1:0] win_in [3][3];
   logic [2:0]        row_ok;
   logic [2:0]        col_ok;
   logic [2:0]        row_exists;
   logic [2:0]        col_exists;
   logic [SLOTS-1:0]  hit;

   // shifted window: rows top to bottom, columns left to right
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         win_in[k][0] = win_ff[k][1];
         win_in[k][1] = win_ff[k][2];
      end
      win_in[0][2] = older_cell;
      win_in[1][2] = newer_cell;
      win_in[2][2] = new_cell;
   end

   always_comb begin
      int y;
      int x;
      int wr;
      int wc;
      logic near;
      for (int k = 0; k < 3; k++) begin
         y = int'(ri) - 2 + k;
         x = int'(ci) - 2 + k;
         row_ok[k] = (y >= 0) && (y < int'(nr));
         col_ok[k] = (x >= 0) && (x < int'(nc));
      end
      // window center positions that this beat completes
      row_exists[0] = 1'b0;
      row_exists[1] = (ri != '0);
      row_exists[2] = ((32'(ri) + 32'd1) == 32'(nr));
      col_exists[0] = 1'b0;
      col_exists[1] = (ci != '0);
      col_exists[2] = ((32'(ci) + 32'd1) == 32'(nc));
      for (int p = 0; p < SLOTS; p++) begin
         wr = (p >= 2) ? 2 : 1;
         wc = 1 + (p & 1);
         near = 1'b0;
         for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
               if ((k - wr <= 1) && (wr - k <= 1) && (j - wc <= 1) && (wc - j <= 1) &&
                   !((k == wr) && (j == wc)) && row_ok[k] && col_ok[j] &&
                   (win_in[k][j] == CLS_MARKED)) begin
                  near = 1'b1;
               end
            end
         end
         hit[p] = row_exists[wr] && col_exists[wc] && row_ok[wr] && col_ok[wc] &&
                  (win_in[wr][wc] == CLS_CANDIDATE) && near;
      end
   end

   always_comb begin
      group.mask      = hit;
      group.up_row    = POS_OUT_W'(32'(ri) - 32'd1);
      group.cur_row   = POS_OUT_W'(32'(ri));
      group.left_col  = POS_OUT_W'(32'(ci) - 32'd1);
      group.right_col = POS_OUT_W'(32'(ci));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[k][j] <= '0;
            end
         end
      end else if (shift_en) begin
         win_ff <= win_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/gncd_outbuf.sv */
// ----------------------------------------------------------------------------
// gncd_outbuf
// Result group register: holds the hits of one window and sends them one beat
// at a time, flagging the last one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gncd_outbuf import gncd_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       load,
   input  gncd_group_type  group,
   output logic            free,
   gncd_rsp_if.source      rsp_bus
);

   logic [SLOTS-1:0] mask_ff;
   logic [SLOTS-1:0] mask_in;
   gncd_group_type   grp_ff;
   logic             beat;
   logic             single;

   assign beat   = rsp_bus.valid && rsp_bus.ready;
   assign single = (mask_ff != '0) && ((mask_ff & (mask_ff - 1'b1)) == '0);
   assign free   = (mask_ff == '0) || (single && rsp_bus.ready);

   always_comb begin
      mask_in = mask_ff;
      if (beat) begin
         mask_in = mask_ff & (mask_ff - 1'b1);   // drop lowest slot
      end
      if (load) begin
         mask_in = group.mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         grp_ff <= group;
      end
   end

   assign rsp_bus.valid       = (mask_ff != '0);
   assign rsp_bus.last_of_run = single;
   assign rsp_bus.hit_row     = (mask_ff[SLOT_UP_LEFT] || mask_ff[SLOT_UP_RIGHT]) ?
                                grp_ff.up_row : grp_ff.cur_row;
   assign rsp_bus.hit_column  = mask_ff[SLOT_UP_LEFT]  ? grp_ff.left_col  :
                                mask_ff[SLOT_UP_RIGHT] ? grp_ff.right_col :
                                mask_ff[SLOT_CUR_LEFT] ? grp_ff.left_col  :
                                grp_ff.right_col;

`ifndef ASSERT_OFF
   a_load_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> (mask_ff == '0) || (single && beat))
      else $error("result group loaded over pending hits");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (beat && !single) |=> rsp_bus.valid)
      else $error("hit run ended before its last beat");
`endif

endmodule

`default_nettype wire

/* hw/rtl/grid_neighbour_class_detector.sv */
// ----------------------------------------------------------------------------
// grid_neighbour_class_detector
// Raster-order neighbor detector: reports class-1 cells next to class-2 cells.
// ----------------------------------------------------------------------------
// Cells enter one beat per cycle in raster order while ready is high; the two
// previous rows live in one MAX_COLUMNS x 4-bit line RAM (read at accept,
// written back as the beat leaves the read stage, with forwarding when both hit
// the same column). Hits are held in the result group register and sent through
// a single result port at one beat per cycle while the receiver is ready. A cell
// that releases hits (up to four at the last row and last column) can hold the
// input, and only when the next cell that releases hits reaches the read stage
// before those beats have left; cells without hits pass at one per cycle. The
// line RAM needs no clearing pass after reset. The user must write row_count and
// column_count only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grid_neighbour_class_detector import gncd_pkg::*; #(
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wr_data,
   gncd_req_if.sink                   req_bus,
   gncd_rsp_if.source                 rsp_bus
);

   localparam int COL_W = $clog2(MAX_COLUMNS);
   localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

   logic [DIM_W-1:0]  row_count_ff, row_count_in;
   logic [DIM_W-1:0]  column_count_ff, column_count_in;
   logic [DIM_W-1:0]  rows_eff, cols_eff;
   logic [ROW_W-1:0]  row_pos_ff, row_pos_in;
   logic [COL_W-1:0]  col_pos_ff, col_pos_in;
   logic              col_wrap, row_wrap;
   logic              accept;

   logic              s1_valid_ff, s1_valid_in;
   logic [CELL_W-1:0] s1_cls_ff;
   logic [COL_W-1:0]  s1_ci_ff;
   logic [ROW_W-1:0]  s1_ri_ff;
   logic              s1_adv;

   logic              fwd_ff;
   logic [LINE_W-1:0] fwd_data_ff;
   logic [LINE_W-1:0] ram_rd_data;
   logic [LINE_W-1:0] line_eff;
   logic [LINE_W-1:0] ram_wr_data;

   gncd_group_type    group;
   logic              buf_free;

   // ---------------- configuration ----------------
   always_comb begin
      row_count_in    = row_count_ff;
      column_count_in = column_count_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_ROW_COUNT:    row_count_in    = csr_wr_data;
            REG_COLUMN_COUNT: column_count_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff    <= DIM_W'(1024);
         column_count_ff <= DIM_W'(1024);
      end else begin
         row_count_ff    <= row_count_in;
         column_count_ff <= column_count_in;
      end
   end

   // zero acts as one, oversize acts as the maximum
   always_comb begin
      rows_eff = row_count_ff;
      if (row_count_ff == '0) begin
         rows_eff = DIM_W'(1);
      end else if (32'(row_count_ff) > MAX_ROWS) begin
         rows_eff = DIM_W'(MAX_ROWS);
      end
      cols_eff = column_count_ff;
      if (column_count_ff == '0) begin
         cols_eff = DIM_W'(1);
      end else if (32'(column_count_ff) > MAX_COLUMNS) begin
         cols_eff = DIM_W'(MAX_COLUMNS);
      end
   end

   // ---------------- raster position ----------------
   assign accept   = req_bus.valid && req_bus.ready;
   assign col_wrap = (32'(col_pos_ff) + 32'd1) >= 32'(cols_eff);
   assign row_wrap = (32'(row_pos_ff) + 32'd1) >= 32'(rows_eff);

   always_comb begin
      row_pos_in = row_pos_ff;
      col_pos_in = col_pos_ff;
      if (accept) begin
         if (col_wrap) begin
            col_pos_in = '0;
            row_pos_in = row_wrap ? '0 : ROW_W'(row_pos_ff + 1'b1);
         end else begin
            col_pos_in = COL_W'(col_pos_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_pos_ff <= '0;
         col_pos_ff <= '0;
      end else begin
         row_pos_ff <= row_pos_in;
         col_pos_ff <= col_pos_in;
      end
   end

   // ---------------- read stage ----------------
   assign s1_adv        = s1_valid_ff && ((group.mask == '0) || buf_free);
   assign req_bus.ready = !s1_valid_ff || s1_adv;
   assign s1_valid_in   = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (accept) begin
            // write back of the leaving beat collides with this read
            fwd_ff <= s1_adv && (s1_ci_ff == col_pos_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cls_ff   <= req_bus.cell_class;
         s1_ci_ff    <= col_pos_ff;
         s1_ri_ff    <= row_pos_ff;
         fwd_data_ff <= ram_wr_data;
      end
   end

   // line word: older row in the high half, newer row in the low half
   assign line_eff    = fwd_ff ? fwd_data_ff : ram_rd_data;
   assign ram_wr_data = {line_eff[CELL_W-1:0], s1_cls_ff};

   gncd_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_COLUMNS)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_ci_ff),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (col_pos_ff),
      .rd_data (ram_rd_data)
   );

   // ---------------- window and judgment ----------------
   gncd_window #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .shift_en   (s1_adv),
      .older_cell (line_eff[LINE_W-1:CELL_W]),
      .newer_cell (line_eff[CELL_W-1:0]),
      .new_cell   (s1_cls_ff),
      .ri         (s1_ri_ff),
      .ci         (s1_ci_ff),
      .nr         (rows_eff),
      .nc         (cols_eff),
      .group      (group)
   );

   // ---------------- result output ----------------
   gncd_outbuf u_outbuf (
      .clock   (clock),
      .reset   (reset),
      .load    (s1_adv && (group.mask != '0)),
      .group   (group),
      .free    (buf_free),
      .rsp_bus (rsp_bus)
   );

`ifndef ASSERT_OFF
   a_stalled_beat_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> s1_valid_ff && $stable(s1_ci_ff) && $stable(s1_ri_ff))
      else $error("stalled cell lost from read stage");

   a_column_in_range: assert property (@(posedge clock) disable iff (reset)
      32'(col_pos_ff) < MAX_COLUMNS)
      else $error("column position beyond line buffer");
`endif

endmodule

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for grid_neighbour_class_detector.
// A clocked driver streams cells from a queue; a monitor tracks a line-buffer
// model of the grid on every accepted cell and checks each hit beat against
// the oldest predicted hit. The grid size is changed between phases, while
// the block is idle, including extreme and out-of-range row counts.
// ----------------------------------------------------------------------------

module tb;
   import gncd_pkg::*;

   localparam int LIMIT_CYCLES = 1_000_000;
   localparam int LONG_HOLD    = 300;
   // columns primed in both line rows; column counts set after priming never go beyond it
   localparam int PRIME_COLS   = 8;

   localparam logic [CELL_W-1:0] BLANK = 2'd0;
   localparam logic [CELL_W-1:0] FILL  = 2'd3;
   localparam logic [CELL_W-1:0] CAND  = CLS_CANDIDATE;
   localparam logic [CELL_W-1:0] MARK  = CLS_MARKED;

   // 3x3 frames: the first has one cell that releases several hits, the second has no
   // marked cell at all (class 3 must not act as marked)
   localparam logic [CELL_W-1:0] RING_3X3 [9] =
      '{MARK, MARK, MARK, MARK, CAND, CAND, CAND, CAND, MARK};
   localparam logic [CELL_W-1:0] NO_MARK_3X3 [9] =
      '{FILL, CAND, BLANK, BLANK, FILL, CAND, CAND, BLANK, FILL};

   typedef struct {
      logic [POS_OUT_W-1:0] hit_row;
      logic [POS_OUT_W-1:0] hit_column;
      logic                 last_of_run;
   } hit_t;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   gncd_req_if req_if ();
   gncd_rsp_if rsp_if ();

   grid_neighbour_class_detector u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_if),
      .rsp_bus     (rsp_if)
   );

   always #1 clock = ~clock;

   // ------------------------------------------------------------------------
   // grid model
   // ------------------------------------------------------------------------
   logic [CELL_W-1:0] line_old [DEF_MAX_COLUMNS] = '{default: '0};
   logic [CELL_W-1:0] line_new [DEF_MAX_COLUMNS] = '{default: '0};
   logic [CELL_W-1:0] win [3][3] = '{default: '{default: '0}};
   int                row_pos   = 0;
   int                col_pos   = 0;
   logic [DIM_W-1:0]  rows_reg  = 11'd1024;
   logic [DIM_W-1:0]  cols_reg  = 11'd1024;

   hit_t              hit_q [$];
   logic [CELL_W-1:0] cell_q [$];

   int  err_cnt     = 0;
   int  hits_seen   = 0;
   int  cycle_cnt   = 0;
   bit  calm        = 1'b0;
   bit  hold_toggle = 1'b0;
   bit  hold_seen   = 1'b0;
   int  hold_left   = 0;
   int  stall_left  = 0;
   int  gap_left    = 0;
   hit_t due;

   function automatic int eff_dim(logic [DIM_W-1:0] v, int cap);
      if (v == 0) return 1;
      if (v > cap) return cap;
      return v;
   endfunction

   // Candidate at (r, c) touching a marked cell; window bottom-right is (ri, ci).
   function automatic bit is_hit(int r, int c, int ri, int ci, int nr, int nc);
      int wr, wc, ny, nx;
      if (r >= nr || c >= nc) return 1'b0;
      wr = r - ri + 2;
      wc = c - ci + 2;
      if (wr < 0 || wr > 2 || wc < 0 || wc > 2) return 1'b0;
      if (win[wr][wc] != CLS_CANDIDATE) return 1'b0;
      for (int y = r - 1; y <= r + 1; y++) begin
         for (int x = c - 1; x <= c + 1; x++) begin
            if (y == r && x == c) continue;
            if (y < 0 || x < 0 || y >= nr || x >= nc) continue;
            ny = y - ri + 2;
            nx = x - ci + 2;
            if (ny < 0 || ny > 2 || nx < 0 || nx > 2) continue;
            if (win[ny][nx] == CLS_MARKED) return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic void step_grid(logic [CELL_W-1:0] cls);
      int   nr, nc, ri, ci;
      int   rows [$];
      int   cols [$];
      hit_t found [$];
      hit_t h;
      nr = eff_dim(rows_reg, DEF_MAX_ROWS);
      nc = eff_dim(cols_reg, DEF_MAX_COLUMNS);
      ri = row_pos;
      ci = col_pos % DEF_MAX_COLUMNS;
      for (int k = 0; k < 3; k++) begin
         win[k][0] = win[k][1];
         win[k][1] = win[k][2];
      end
      win[0][2] = line_old[ci];
      win[1][2] = line_new[ci];
      win[2][2] = cls;
      line_old[ci] = line_new[ci];
      line_new[ci] = cls;

      if (ri >= 1) rows.push_back(ri - 1);
      if (ri == nr - 1) rows.push_back(ri);
      if (ci >= 1) cols.push_back(ci - 1);
      if (ci == nc - 1) cols.push_back(ci);

      foreach (rows[a]) begin
         foreach (cols[b]) begin
            if (is_hit(rows[a], cols[b], ri, ci, nr, nc)) begin
               h.hit_row     = POS_OUT_W'(rows[a]);
               h.hit_column  = POS_OUT_W'(cols[b]);
               h.last_of_run = 1'b0;
               found.push_back(h);
            end
         end
      end
      if (found.size() != 0) found[found.size()-1].last_of_run = 1'b1;
      foreach (found[i]) hit_q.push_back(found[i]);

      if (ci + 1 >= nc) begin
         col_pos = 0;
         row_pos = (ri + 1 >= nr) ? 0 : ri + 1;
      end else begin
         col_pos = ci + 1;
      end
   endfunction

   // ------------------------------------------------------------------------
   // cell driver
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_if.valid <= 1'b0;
         end else if (!calm && cell_q.size() != 0 && $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(0, 7);
            req_if.valid <= 1'b0;
         end else if (cell_q.size() != 0) begin
            req_if.valid      <= 1'b1;
            req_if.cell_class <= cell_q.pop_front();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // hit receiver: random stall bursts plus one long hold-off on request
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else if (hold_seen != hold_toggle) begin
         hold_seen = hold_toggle;
         hold_left = LONG_HOLD - 1;
         rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 7);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // monitor and scoreboard
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) step_grid(req_if.cell_class);
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         hits_seen++;
         if (hit_q.size() == 0) begin
            err_cnt++;
            $display("%0t: unexpected hit beat, expected none, actual row %0d col %0d last %0b",
                     $time, rsp_if.hit_row, rsp_if.hit_column, rsp_if.last_of_run);
         end else begin
            due = hit_q.pop_front();
            if (rsp_if.hit_row !== due.hit_row) begin
               err_cnt++;
               $display("%0t: hit_row expected %0d actual %0d",
                        $time, due.hit_row, rsp_if.hit_row);
            end
            if (rsp_if.hit_column !== due.hit_column) begin
               err_cnt++;
               $display("%0t: hit_column expected %0d actual %0d",
                        $time, due.hit_column, rsp_if.hit_column);
            end
            if (rsp_if.last_of_run !== due.last_of_run) begin
               err_cnt++;
               $display("%0t: last_of_run expected %0b actual %0b",
                        $time, due.last_of_run, rsp_if.last_of_run);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt >= LIMIT_CYCLES) begin
         $display("%0t: timeout, %0d hits still expected", $time, hit_q.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == REG_ROW_COUNT) rows_reg = val;
      else if (idx == REG_COLUMN_COUNT) cols_reg = val;
      @(negedge clock);
   endtask

   task automatic set_dims(logic [DIM_W-1:0] nrows, logic [DIM_W-1:0] ncols);
      write_reg(REG_ROW_COUNT, nrows);
      write_reg(REG_COLUMN_COUNT, ncols);
   endtask

   // wait for the pipe to drain; cells that release no hit may still be inside
   task automatic settle();
      while (cell_q.size() != 0 || req_if.valid || hit_q.size() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   function automatic logic [CELL_W-1:0] rand_cell();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return CAND;
      if (r < 65) return MARK;
      if (r < 85) return BLANK;
      return FILL;
   endfunction

   function automatic void queue_random(int n);
      repeat (n) cell_q.push_back(rand_cell());
   endfunction

   // mostly small sizes; with wide set, now and then an extreme or out-of-range
   // size (rows only: the line RAM is only primed up to PRIME_COLS columns)
   function automatic logic [DIM_W-1:0] pick_dim(int small_max, bit wide);
      int sel;
      sel = $urandom_range(0, 11);
      if (sel == 0) return '0;
      if (wide) begin
         if (sel == 1) return '1;
         if (sel == 2) return DIM_W'(DEF_MAX_ROWS);
         if (sel == 3) return DIM_W'($urandom_range(DEF_MAX_ROWS + 1, 2047));
      end
      return DIM_W'($urandom_range(1, small_max));
   endfunction

   initial begin
      int pushed;
      int hit_base;
      int phase_no;
      int n;
      req_if.valid      = 1'b0;
      req_if.cell_class = '0;
      rsp_if.ready      = 1'b0;
      csr_wr_en         = 1'b0;
      csr_index         = '0;
      csr_wr_data       = '0;
      reset             = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // a few cells at reset size, then two rows of PRIME_COLS columns so that
      // both line rows hold written data in every column used later
      queue_random(12);
      settle();
      write_reg(REG_COLUMN_COUNT, DIM_W'(PRIME_COLS));
      queue_random(2 * PRIME_COLS);
      settle();

      // 1x1 grid from zero sizes, entered mid-frame
      set_dims('0, '0);
      cell_q = '{BLANK, CAND, MARK, FILL, CAND, MARK};
      settle();

      set_dims(DIM_W'(3), DIM_W'(3));
      foreach (RING_3X3[i]) cell_q.push_back(RING_3X3[i]);
      foreach (NO_MARK_3X3[i]) cell_q.push_back(NO_MARK_3X3[i]);
      settle();

      pushed   = 0;
      phase_no = 0;
      hit_base = hits_seen;
      while ((pushed < 160 || hits_seen - hit_base < 60) && phase_no < 10) begin
         settle();
         case ($urandom_range(0, 2))
            0:       write_reg(REG_ROW_COUNT, pick_dim(6, 1'b1));
            1:       write_reg(REG_COLUMN_COUNT, pick_dim(PRIME_COLS, 1'b0));
            default: set_dims(pick_dim(6, 1'b1), pick_dim(PRIME_COLS, 1'b0));
         endcase
         n = $urandom_range(5, 40);
         if (phase_no == 1) begin
            // long receiver hold-off while cells keep coming
            set_dims(DIM_W'(5), DIM_W'(6));
            n = 80;
            hold_toggle = ~hold_toggle;
         end
         queue_random(n);
         pushed += n;
         phase_no++;
      end

      // closing stretch at full rate on both sides
      settle();
      calm = 1'b1;
      set_dims(DIM_W'(4), DIM_W'(5));
      queue_random(40);
      settle();

      if (err_cnt == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/gncd_pkg.sv
hw/rtl/gncd_if.sv
hw/rtl/gncd_ram.sv
hw/rtl/gncd_window.sv
hw/rtl/gncd_outbuf.sv
hw/rtl/grid_neighbour_class_detector.sv
dv/tb.sv
